// ----- hdl/lmd_pkg.sv -----
package lmd_pkg;

   localparam int POS_BITS = 10;
   localparam int CFG_BITS = 11;
   localparam int RAD_BITS = 3;
   localparam int IDX_BITS = 2;

   typedef enum logic [IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_WINDOW_RADIUS = 2'd2
   } csr_index_type;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd1024;
   localparam logic [RAD_BITS-1:0] RADIUS_RESET = 3'd1;

   typedef struct packed {
      logic                centre_valid;
      logic [POS_BITS-1:0] centre_row;
      logic [POS_BITS-1:0] centre_col;
      logic                judge;
      logic                last_of_frame;
   } meta_type;

endpackage

// ----- hdl/lmd_req_if.sv -----
interface lmd_req_if #(parameter int PIXEL_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel;
   logic                         first_of_frame;

   modport source (output valid, pixel, first_of_frame, input ready);
   modport sink (input valid, pixel, first_of_frame, output ready);
endinterface

// ----- hdl/lmd_rsp_if.sv -----
interface lmd_rsp_if #(parameter int PIXEL_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         centre_valid;
   logic [9:0]                   centre_row;
   logic [9:0]                   centre_col;
   logic                         is_peak;
   logic signed [PIXEL_BITS-1:0] peak_value;
   logic                         last_of_frame;

   modport source (output valid, centre_valid, centre_row, centre_col, is_peak,
      peak_value, last_of_frame, input ready);
   modport sink (input valid, centre_valid, centre_row, centre_col, is_peak,
      peak_value, last_of_frame, output ready);
endinterface

// ----- hdl/lmd_csr_if.sv -----
interface lmd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [10:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/local_maximum_detect_2d.sv -----
// Pipeline: an accepted request moves through stage B, stage C and the result register, where its result is offered.
// Throughput: one request per cycle; a stalled result holds the whole pipeline.
// Storage: 2*MAX_RADIUS line RAMs of MAX_WIDTH words feed a chain of
// 2*MAX_RADIUS+1 column cells that forms the window.
// Reset: synchronous, active high; clears positions, valids and registers to
// width 1024, height 1024, radius 1. Line and window contents are undefined.
module local_maximum_detect_2d
   import lmd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 4,
   parameter int PIXEL_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   lmd_req_if.sink      req_chan,
   lmd_rsp_if.source    rsp_chan,
   lmd_csr_if.sink      csr_chan
);

   localparam int NROWS = 2 * MAX_RADIUS + 1;
   localparam int NLINE = 2 * MAX_RADIUS;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RWB   = $clog2(MAX_HEIGHT);
   localparam int RADW  = $clog2(MAX_RADIUS + 1);
   localparam int XB    = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 ** CFG_BITS + 2);

   // configuration registers
   logic [CFG_BITS-1:0] width_ff, height_ff;
   logic [RAD_BITS-1:0] radius_ff;

   logic [XB-1:0]   w_x, h_x, r_x;
   logic [RADW-1:0] r;

   // position counters
   logic [CW-1:0]  col_ff, col_in, col_cur;
   logic [RWB-1:0] row_ff, row_in, row_cur;
   logic [XB-1:0]  col_x, row_x;

   logic     adv, acc;
   meta_type meta_a;

   // stage B: line RAM data arrives
   logic                         b_valid_ff;
   logic signed [PIXEL_BITS-1:0] b_px_ff;
   logic [CW-1:0]                b_col_ff;
   meta_type                     b_meta_ff;
   logic [PIXEL_BITS-1:0]        rd [NLINE];

   // stage C: window holds the new column
   logic     c_valid_ff;
   meta_type c_meta_ff;

   // result register
   logic                         rsp_valid_ff;
   logic                         rsp_cv_ff, rsp_peak_ff, rsp_last_ff;
   logic [POS_BITS-1:0]          rsp_row_ff, rsp_col_ff;
   logic signed [PIXEL_BITS-1:0] rsp_value_ff;

   logic signed [PIXEL_BITS-1:0] win [NROWS+1][NROWS];
   logic signed [PIXEL_BITS-1:0] centre;
   logic                         hits [NROWS];
   logic                         any_hit, peak;

   // configuration write; always ready
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_chan.data;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_chan.data;
            CSR_WINDOW_RADIUS: radius_ff <= csr_chan.data[RAD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // saturate registers to their legal ranges
   always_comb begin
      w_x = XB'(width_ff);
      if (w_x < XB'(3)) w_x = XB'(3);
      if (w_x > XB'(MAX_WIDTH)) w_x = XB'(MAX_WIDTH);
      h_x = XB'(height_ff);
      if (h_x < XB'(3)) h_x = XB'(3);
      if (h_x > XB'(MAX_HEIGHT)) h_x = XB'(MAX_HEIGHT);
      r_x = XB'(radius_ff);
      if (r_x < XB'(1)) r_x = XB'(1);
      if (r_x > XB'(MAX_RADIUS)) r_x = XB'(MAX_RADIUS);
   end
   assign r = RADW'(r_x);

   // the whole pipeline advances unless a result waits
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign acc            = req_chan.valid && adv;

   // stage A: place the request and classify its centre
   always_comb begin
      col_cur = req_chan.first_of_frame ? '0 : col_ff;
      row_cur = req_chan.first_of_frame ? '0 : row_ff;
      col_x   = XB'(col_cur);
      row_x   = XB'(row_cur);
      meta_a  = '0;
      if (row_x >= r_x && col_x >= r_x) begin
         meta_a.centre_valid = 1'b1;
         meta_a.centre_row   = POS_BITS'(row_x - r_x);
         meta_a.centre_col   = POS_BITS'(col_x - r_x);
         meta_a.judge        = row_x >= {r_x[XB-2:0], 1'b0} && col_x >= {r_x[XB-2:0], 1'b0};
      end
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (col_x + XB'(1) >= w_x) begin
            col_in = '0;
            if (row_x + XB'(1) >= h_x) begin
               meta_a.last_of_frame = 1'b1;
               row_in = '0;
            end else begin
               row_in = row_cur + RWB'(1);
            end
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (adv) begin
            b_valid_ff   <= acc;
            c_valid_ff   <= b_valid_ff;
            rsp_valid_ff <= c_valid_ff;
         end
      end
   end

   // payload pipeline; hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         b_px_ff      <= req_chan.pixel;
         b_col_ff     <= col_cur;
         b_meta_ff    <= meta_a;
         c_meta_ff    <= b_meta_ff;
         rsp_cv_ff    <= c_meta_ff.centre_valid;
         rsp_row_ff   <= c_meta_ff.centre_row;
         rsp_col_ff   <= c_meta_ff.centre_col;
         rsp_last_ff  <= c_meta_ff.last_of_frame;
         rsp_peak_ff  <= peak;
         rsp_value_ff <= peak ? centre : '0;
      end
   end

   // line RAMs: RAM k holds row-1-k; each pushes its old word down the chain
   for (genvar k = 0; k < NLINE; k++) begin : g_line
      lmd_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock (clock),
         .we    (adv && b_valid_ff),
         .waddr (b_col_ff),
         .wdata ((k == 0) ? b_px_ff : rd[(k == 0) ? 0 : k - 1]),
         .re    (adv),
         .raddr (col_cur),
         .rdata (rd[k])
      );
   end

   // new column: current pixel on top, older rows below
   always_comb begin
      win[0][0] = b_px_ff;
      for (int d = 1; d < NROWS; d++) begin
         win[0][d] = $signed(rd[d-1]);
      end
   end

   // window as a chain of column cells; cell k holds column col-k
   for (genvar k = 0; k < NROWS; k++) begin : g_cell
      lmd_cell #(
         .PIXEL_BITS (PIXEL_BITS),
         .NROWS      (NROWS),
         .RADW       (RADW),
         .IDX        (k)
      ) u_cell (
         .clock    (clock),
         .shift_en (adv && b_valid_ff),
         .col_in   (win[k]),
         .col_out  (win[k+1]),
         .centre   (centre),
         .radius   (r),
         .hit      (hits[k])
      );
   end

   // pick the centre at column r, row r; drop peak on any tie or larger
   always_comb begin
      centre  = win[1][0];
      any_hit = 1'b0;
      for (int k = 0; k < NROWS; k++) begin
         if (RADW'(k) == r) centre = win[k+1][k];
         any_hit = any_hit | hits[k];
      end
      peak = c_meta_ff.judge && !any_hit;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.centre_valid  = rsp_cv_ff;
   assign rsp_chan.centre_row    = rsp_row_ff;
   assign rsp_chan.centre_col    = rsp_col_ff;
   assign rsp_chan.is_peak       = rsp_peak_ff;
   assign rsp_chan.peak_value    = rsp_value_ff;
   assign rsp_chan.last_of_frame = rsp_last_ff;

endmodule

// ----- hdl/lmd_ram.sv -----
module lmd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/lmd_cell.sv -----
module lmd_cell
   import lmd_pkg::*;
#(
   parameter int PIXEL_BITS = 16,
   parameter int NROWS      = 9,
   parameter int RADW       = 3,
   parameter int IDX        = 0
) (
   input  logic                         clock,
   input  logic                         shift_en,
   input  logic signed [PIXEL_BITS-1:0] col_in  [NROWS],
   output logic signed [PIXEL_BITS-1:0] col_out [NROWS],
   input  logic signed [PIXEL_BITS-1:0] centre,
   input  logic [RADW-1:0]              radius,
   output logic                         hit
);

   logic signed [PIXEL_BITS-1:0] col_ff [NROWS];
   logic [RADW:0]                twice_r;
   logic                         col_used;
   logic                         hits [NROWS];

   // hold one window column, hand it on when a new column enters
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out  = col_ff;
   assign twice_r  = {radius, 1'b0};
   assign col_used = (RADW+1)'(IDX) <= twice_r;

   always_comb begin
      hit = 1'b0;
      for (int d = 0; d < NROWS; d++) begin
         hits[d] = col_used && ((RADW+1)'(d) <= twice_r)
                   && !((RADW+1)'(IDX) == {1'b0, radius} && (RADW+1)'(d) == {1'b0, radius})
                   && (col_ff[d] >= centre);
         hit = hit | hits[d];
      end
   end

endmodule
